>>> src/rfsw_pkg.sv
// Package for the RF switch pulse frame decoder.
// Holds widths, frame positions, register indexes, reset values and shared types.
// No dependencies.
package rfsw_pkg;

  localparam int FRAME_PULSES = 50;

  localparam int WIDTH_W    = 8;
  localparam int SCALE_W    = 8;
  localparam int LEVEL_W    = 16;
  localparam int IDX_W      = 6;
  localparam int BITS_W     = 24;
  localparam int ADDR_W     = 20;
  localparam int UNIT_W     = 3;
  localparam int PKT_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [IDX_W-1:0] IDX_MAX    = '1;
  localparam logic [IDX_W-1:0] DATA_FIRST = IDX_W'(2);
  localparam logic [IDX_W-1:0] DATA_LAST  = IDX_W'(FRAME_PULSES - 2);
  localparam logic [IDX_W-1:0] LAST_POS   = IDX_W'(FRAME_PULSES - 1);

  localparam logic [UNIT_W-1:0] UNIT_RESERVED = 3'd3;
  localparam logic [UNIT_W-1:0] UNIT_ALIAS    = 3'd4;
  localparam logic [3:0]        ADDR_TOP_ALL  = 4'hf;

  localparam logic [SCALE_W-1:0] PULSE_SCALE_RST    = 8'd30;
  localparam logic [LEVEL_W-1:0] LONG_THRESHOLD_RST = 16'd400;
  localparam logic [LEVEL_W-1:0] LONG_MAX_RST       = 16'd900;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PULSE_SCALE    = 2'd0,
    REG_LONG_THRESHOLD = 2'd1,
    REG_LONG_MAX       = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [SCALE_W-1:0] pulse_scale;
    logic [LEVEL_W-1:0] long_threshold;
    logic [LEVEL_W-1:0] long_max;
  } cfg_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] pulse_width;
    logic               last_of_frame;
  } pulse_t;

endpackage

>>> src/rfsw_if.sv
// Channel interfaces of the RF switch pulse frame decoder: pulse items in, frame items out.
// Depends on rfsw_pkg.
interface rfsw_in_if import rfsw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WIDTH_W-1:0] pulse_width;
  logic               last_of_frame;

  modport source (output valid, pulse_width, last_of_frame, input ready);
  modport sink   (input valid, pulse_width, last_of_frame, output ready);
endinterface

interface rfsw_out_if import rfsw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              frame_valid;
  logic [ADDR_W-1:0] address;
  logic [UNIT_W-1:0] unit;
  logic              all_units;
  logic              switch_on;
  logic [PKT_W-1:0]  packet_number;

  modport source (output valid, frame_valid, address, unit, all_units, switch_on,
                  packet_number, input ready);
  modport sink   (input valid, frame_valid, address, unit, all_units, switch_on,
                  packet_number, output ready);
endinterface

>>> src/rfsw_cfg_regs.sv
// Configuration registers of the RF switch pulse frame decoder.
// Depends on rfsw_pkg.
module rfsw_cfg_regs import rfsw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_scale    <= PULSE_SCALE_RST;
      cfg.long_threshold <= LONG_THRESHOLD_RST;
      cfg.long_max       <= LONG_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PULSE_SCALE:    cfg.pulse_scale    <= cfg_wdata[SCALE_W-1:0];
        REG_LONG_THRESHOLD: cfg.long_threshold <= cfg_wdata[LEVEL_W-1:0];
        REG_LONG_MAX:       cfg.long_max       <= cfg_wdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> src/rfsw_in_stage.sv
// Input register of the RF switch pulse frame decoder: holds one pulse item for the core.
// Depends on rfsw_pkg and rfsw_if.
module rfsw_in_stage import rfsw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  rfsw_in_if.sink     pulses,
  input  logic        take,
  output logic        s1_valid,
  output pulse_t      s1
);

  assign pulses.ready = !s1_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pulses.ready) begin
      s1_valid <= pulses.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pulses.valid && pulses.ready) begin
      s1.pulse_width   <= pulses.pulse_width;
      s1.last_of_frame <= pulses.last_of_frame;
    end
  end

endmodule

>>> src/rfsw_frame_core.sv
// Frame core: scales and classifies each pulse, collects data bits, checks the frame
// and holds the result register. Depends on rfsw_pkg and rfsw_if.
module rfsw_frame_core import rfsw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        s1_valid,
  input  pulse_t      s1,
  output logic        take,
  rfsw_out_if.source  frames
);

  logic [IDX_W-1:0]  pulse_index, pulse_index_next;
  logic [BITS_W-1:0] bit_shift, bit_shift_next;
  logic              frame_bad, frame_bad_next;
  logic [PKT_W-1:0]  packet_count;
  logic              out_valid;

  logic [LEVEL_W-1:0] scaled;
  logic               is_long;
  logic               data_pos;
  logic               load;
  logic [ADDR_W-1:0]  addr;
  logic [UNIT_W-1:0]  unit_raw;
  logic [UNIT_W-1:0]  unit_map;
  logic               group;
  logic               ok;

  // Non-last pulses never produce a result, so they pass even while the output stalls.
  assign take = s1_valid && (!s1.last_of_frame || !out_valid || frames.ready);
  assign load = take && s1.last_of_frame;

  always_comb begin
    scaled   = LEVEL_W'(s1.pulse_width) * LEVEL_W'(cfg.pulse_scale);
    is_long  = scaled > cfg.long_threshold;
    data_pos = (pulse_index >= DATA_FIRST) && (pulse_index <= DATA_LAST) && !pulse_index[0];

    frame_bad_next = frame_bad;
    bit_shift_next = bit_shift;
    if (pulse_index > LAST_POS) begin
      frame_bad_next = 1'b1;
    end else if (data_pos) begin
      if (is_long && (scaled > cfg.long_max)) frame_bad_next = 1'b1;
      bit_shift_next = {bit_shift[BITS_W-2:0], is_long};
    end else if (pulse_index == LAST_POS) begin
      if (is_long) frame_bad_next = 1'b1;
    end

    // saturate so an overlong frame stays marked as too long
    pulse_index_next = (pulse_index == IDX_MAX) ? pulse_index : pulse_index + 1'b1;

    addr     = bit_shift_next[BITS_W-1:4];
    unit_raw = bit_shift_next[3:1];
    unit_map = (unit_raw == UNIT_ALIAS) ? UNIT_RESERVED : unit_raw;
    group    = unit_raw > UNIT_ALIAS;
    ok = !frame_bad_next && (pulse_index == LAST_POS) && (bit_shift_next != '0)
         && (addr != '0) && (addr[ADDR_W-1 -: 4] != ADDR_TOP_ALL)
         && (unit_raw != UNIT_RESERVED);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_index  <= '0;
      bit_shift    <= '0;
      frame_bad    <= 1'b0;
      packet_count <= '0;
    end else if (take) begin
      if (s1.last_of_frame) begin
        pulse_index <= '0;
        bit_shift   <= '0;
        frame_bad   <= 1'b0;
        if (ok) packet_count <= packet_count + 1'b1;
      end else begin
        pulse_index <= pulse_index_next;
        bit_shift   <= bit_shift_next;
        frame_bad   <= frame_bad_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (frames.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frames.frame_valid   <= ok;
      frames.address       <= ok ? addr : '0;
      frames.unit          <= ok ? unit_map : '0;
      frames.all_units     <= ok && group;
      frames.switch_on     <= ok && (group ? bit_shift_next[0] : !bit_shift_next[0]);
      frames.packet_number <= ok ? packet_count : '0;
    end
  end

  assign frames.valid = out_valid;

`ifndef SYNTHESIS
  a_valid_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && frames.frame_valid |->
      frames.address != '0 && frames.address[ADDR_W-1 -: 4] != ADDR_TOP_ALL
      && frames.unit != UNIT_ALIAS)
    else $error("valid frame result carries a rejected address or unit");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frames.frame_valid |->
      frames.address == '0 && frames.unit == '0 && !frames.all_units
      && !frames.switch_on && frames.packet_number == '0)
    else $error("invalid frame result has nonzero fields");

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    load |=> pulse_index == '0 && bit_shift == '0 && !frame_bad)
    else $error("frame state not cleared after last pulse");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    load && ok |=> packet_count == $past(packet_count) + 1'b1)
    else $error("packet counter did not advance on a valid frame");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !(load && ok) |=> packet_count == $past(packet_count))
    else $error("packet counter moved without a valid frame");
`endif

endmodule

>>> src/rf_switch_pulse_frame_decoder.sv
// Top level of the RF switch pulse frame decoder.
// Depends on rfsw_pkg, rfsw_if, rfsw_cfg_regs, rfsw_in_stage and rfsw_frame_core.
//
// Usage:
//   pulses: one item per received pulse or gap (pulse_width, last_of_frame).
//   frames: one item per frame, produced for the pulse that has last_of_frame set.
//   cfg_we/cfg_index/cfg_wdata: write pulse_scale (0), long_threshold (1),
//   long_max (2); other indexes are ignored. Write only while the block is idle.
// Path: the last pulse passes the input register, then the result register
// behind the 8x8 scale multiply and frame checks, which raises frames.valid.
// Throughput: one pulse item per cycle, except while a final pulse waits in the
// input register for the result register to free up.
// Reset (rst, synchronous) restores the register defaults 30/400/900, clears the
// frame position, the data bits and the packet counter, and empties both stages.
// When the receiver stalls, the pending frame item holds in the result register;
// non-final pulses keep flowing in, and a final pulse waits in the input register
// until the result register frees up, which then holds off pulses.ready.
module rf_switch_pulse_frame_decoder import rfsw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  rfsw_in_if.sink               pulses,
  rfsw_out_if.source            frames
);

  cfg_t   cfg;
  logic   take;
  logic   s1_valid;
  pulse_t s1;

  rfsw_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rfsw_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .pulses   (pulses),
    .take     (take),
    .s1_valid (s1_valid),
    .s1       (s1)
  );

  rfsw_frame_core u_frame_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1       (s1),
    .take     (take),
    .frames   (frames)
  );

endmodule

>>> bench/tb_rf_switch_pulse_frame_decoder.sv
// Testbench for rf_switch_pulse_frame_decoder: drives pulse items, predicts each frame item
// from its own decoder state and checks all fields of every frame item.
// Depends on rfsw_pkg, rfsw_if and the decoder RTL.
`timescale 1ns / 100ps

module tb_rf_switch_pulse_frame_decoder;
  import rfsw_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int RANDOM_PULSES = 500;
  localparam int RANDOM_FRAMES = 10;
  localparam int NO_OVER     = -1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic              frame_valid;
    logic [ADDR_W-1:0] address;
    logic [UNIT_W-1:0] unit;
    logic              all_units;
    logic              switch_on;
    logic [PKT_W-1:0]  packet_number;
  } frame_t;

  typedef enum {W_SHORT, W_LONG, W_OVER, W_ANY} width_kind_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rfsw_in_if  pulse_bus ();
  rfsw_out_if frame_bus ();

  rf_switch_pulse_frame_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pulses    (pulse_bus),
    .frames    (frame_bus)
  );

  // decoder copy: configuration and frame state
  logic [SCALE_W-1:0] cfg_scale = PULSE_SCALE_RST;
  logic [LEVEL_W-1:0] cfg_thr   = LONG_THRESHOLD_RST;
  logic [LEVEL_W-1:0] cfg_max   = LONG_MAX_RST;
  logic [IDX_W-1:0]   frame_pos   = '0;
  logic [BITS_W-1:0]  data_bits   = '0;
  logic               frame_bad   = 1'b0;
  logic [PKT_W-1:0]   valid_count = '0;

  frame_t pending_frames[$];
  int     mismatch_count   = 0;
  int     pulses_sent      = 0;
  int     frames_predicted = 0;
  int     send_calm_left   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit decode_pulse(input logic [WIDTH_W-1:0] w, input logic last,
                                      output frame_t res);
    int unsigned       scaled;
    logic              is_long;
    logic [IDX_W-1:0]  p;
    logic [ADDR_W-1:0] addr;
    logic [UNIT_W-1:0] u;
    logic              cmd;
    logic              ok;
    scaled  = w * cfg_scale;
    is_long = scaled > cfg_thr;
    p       = frame_pos;
    res     = '0;
    if (p > LAST_POS) begin
      frame_bad = 1'b1;
    end else if (p >= DATA_FIRST && p <= DATA_LAST && !p[0]) begin
      if (is_long && scaled > cfg_max) frame_bad = 1'b1;
      data_bits = {data_bits[BITS_W-2:0], is_long};
    end else if (p == LAST_POS) begin
      if (is_long) frame_bad = 1'b1;
    end
    if (frame_pos != IDX_MAX) frame_pos = frame_pos + 1'b1;
    if (!last) return 1'b0;

    addr = data_bits[BITS_W-1:4];
    u    = data_bits[3:1];
    cmd  = data_bits[0];
    ok   = !frame_bad && p == LAST_POS && data_bits != '0 && addr != '0
           && addr[ADDR_W-1:ADDR_W-4] != ADDR_TOP_ALL && u != UNIT_RESERVED;
    if (ok) begin
      if (u == UNIT_ALIAS) u = UNIT_RESERVED;
      res.frame_valid   = 1'b1;
      res.address       = addr;
      res.unit          = u;
      res.all_units     = u > UNIT_ALIAS;
      res.switch_on     = (u > UNIT_ALIAS) ? cmd : ~cmd;
      res.packet_number = valid_count;
      valid_count       = valid_count + 1'b1;
    end
    frame_pos = '0;
    data_bits = '0;
    frame_bad = 1'b0;
    return 1'b1;
  endfunction

  // Try to find a raw width that lands in the wanted class under the current settings; else a random one.
  function automatic logic [WIDTH_W-1:0] pick_width(input width_kind_t kind);
    logic [WIDTH_W-1:0] start;
    logic [WIDTH_W-1:0] w;
    int unsigned        s;
    start = WIDTH_W'($urandom_range(0, 255));
    if (kind == W_ANY) return start;
    for (int i = 0; i < 264; i++) begin
      w = (i < 8) ? WIDTH_W'($urandom_range(0, 255)) : WIDTH_W'(start + i);
      s = w * cfg_scale;
      case (kind)
        W_SHORT: if (s <= cfg_thr) return w;
        W_LONG:  if (s > cfg_thr && s <= cfg_max) return w;
        W_OVER:  if (s > cfg_thr && s > cfg_max) return w;
        default: return w;
      endcase
    end
    return start;
  endfunction

  function automatic int pick_gap();
    int r;
    if (send_calm_left > 0) begin
      send_calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r == 0) begin
      send_calm_left = $urandom_range(20, 120);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  function automatic logic [BITS_W-1:0] random_data();
    int r;
    logic [ADDR_W-1:0] addr;
    r    = $urandom_range(0, 99);
    addr = ADDR_W'($urandom);
    if (r >= 80 && r < 88) addr[ADDR_W-1:ADDR_W-4] = ADDR_TOP_ALL;
    else if (r >= 88 && r < 93) addr = '0;
    else if (r >= 93) return BITS_W'($urandom);
    return {addr, UNIT_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1))};
  endfunction

  task automatic send_pulse(input logic [WIDTH_W-1:0] w, input logic last);
    int     gap;
    frame_t res;
    gap = pick_gap();
    if (gap > 0) begin
      pulse_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pulse_bus.valid         <= 1'b1;
    pulse_bus.pulse_width   <= w;
    pulse_bus.last_of_frame <= last;
    @(posedge clk);
    while (pulse_bus.ready !== 1'b1) @(posedge clk);
    pulses_sent++;
    if (decode_pulse(w, last, res)) begin
      pending_frames.push_back(res);
      frames_predicted++;
    end
  endtask

  // Data pulses follow the bits; over_pos forces one data pulse past long_max.
  task automatic send_frame(input logic [BITS_W-1:0] data, input int length,
                            input bit last_long, input int over_pos);
    width_kind_t kind;
    for (int p = 0; p < length; p++) begin
      if (p >= DATA_FIRST && p <= DATA_LAST && p % 2 == 0)
        kind = (p == over_pos) ? W_OVER : (data[BITS_W-1-(p-2)/2] ? W_LONG : W_SHORT);
      else if (p == LAST_POS)
        kind = last_long ? W_LONG : W_SHORT;
      else
        kind = W_ANY;
      send_pulse(pick_width(kind), p == length - 1);
    end
  endtask

  task automatic wait_idle();
    pulse_bus.valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    // two register stages behind the last pulse
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [SCALE_W-1:0] scale, input logic [LEVEL_W-1:0] thr,
                            input logic [LEVEL_W-1:0] lmax);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_PULSE_SCALE;
    cfg_wdata <= {8'($urandom_range(0, 255)), scale};
    @(posedge clk);
    cfg_index <= REG_LONG_THRESHOLD;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_index <= REG_LONG_MAX;
    cfg_wdata <= lmax;
    @(posedge clk);
    // unmapped index must leave every register alone
    cfg_index <= REG_UNUSED;
    cfg_wdata <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_scale = scale;
    cfg_thr   = thr;
    cfg_max   = lmax;
    @(posedge clk);
  endtask

  task automatic test_field_checks();
    send_frame({20'h00001, 3'd0, 1'b0}, FRAME_PULSES, 1'b0, NO_OVER);
    send_frame({20'hEFFFF, 3'd7, 1'b1}, FRAME_PULSES, 1'b0, NO_OVER);
    send_frame({20'hABCDE, UNIT_ALIAS, 1'b1}, FRAME_PULSES, 1'b0, NO_OVER);
    send_frame({20'h54321, 3'd5, 1'b0}, FRAME_PULSES, 1'b0, NO_OVER);
    send_frame({20'h6789A, 3'd6, 1'b1}, FRAME_PULSES, 1'b0, NO_OVER);
    send_frame({20'h13579, UNIT_RESERVED, 1'b0}, FRAME_PULSES, 1'b0, NO_OVER);
    send_frame({20'hF1234, 3'd1, 1'b0}, FRAME_PULSES, 1'b0, NO_OVER);
    send_frame({20'h00000, 3'd2, 1'b1}, FRAME_PULSES, 1'b0, NO_OVER);
    send_frame(24'h000000, FRAME_PULSES, 1'b0, NO_OVER);
    send_frame(24'hFFFFFF, FRAME_PULSES, 1'b0, NO_OVER);
    send_frame({20'h2468A, 3'd2, 1'b0}, FRAME_PULSES, 1'b1, NO_OVER);
    send_frame({20'h2468A, 3'd2, 1'b0}, FRAME_PULSES, 1'b0, 10);
  endtask

  task automatic test_frame_length();
    int lengths[8] = '{1, 2, 49, 51, 64, 65, 72, FRAME_PULSES};
    foreach (lengths[i])
      send_frame({20'h35791, 3'd1, 1'b1}, lengths[i], 1'b0, NO_OVER);
  endtask

  task automatic test_config_extremes();
    set_config(8'd1, 16'd0, 16'hFFFF);
    send_frame({20'h2468A, 3'd2, 1'b0}, FRAME_PULSES, 1'b0, NO_OVER);
    send_frame(random_data(), FRAME_PULSES, 1'b0, NO_OVER);
    set_config(8'd255, 16'd0, 16'd0);
    send_frame({20'h2468A, 3'd2, 1'b0}, FRAME_PULSES, 1'b0, NO_OVER);
    send_frame({20'h00000, 3'd0, 1'b0}, FRAME_PULSES, 1'b0, NO_OVER);
    set_config(8'd255, 16'hFFFF, 16'hFFFF);
    send_frame(random_data(), FRAME_PULSES, 1'b0, NO_OVER);
    set_config(8'd0, 16'd0, 16'd0);
    send_frame(random_data(), FRAME_PULSES, 1'b0, NO_OVER);
    set_config(8'd255, 16'd32000, 16'hFFFF);
    send_frame({20'hEDCBA, 3'd7, 1'b0}, FRAME_PULSES, 1'b0, NO_OVER);
    send_frame({20'h2468A, 3'd2, 1'b0}, FRAME_PULSES, 1'b0, 48);
  endtask

  task automatic test_random_frames();
    int          pulse_base;
    int          frame_base;
    int          phase;
    int          r;
    int unsigned scale;
    int unsigned thr;
    int unsigned lmax;
    pulse_base = pulses_sent;
    frame_base = frames_predicted;
    phase      = 0;
    while (pulses_sent - pulse_base < RANDOM_PULSES
           || frames_predicted - frame_base < RANDOM_FRAMES) begin
      if (phase == 0) begin
        set_config(PULSE_SCALE_RST, LONG_THRESHOLD_RST, LONG_MAX_RST);
      end else begin
        scale = $urandom_range(1, 255);
        thr   = $urandom_range(0, scale * 254);
        lmax  = thr + $urandom_range(scale, scale * 255);
        if ($urandom_range(0, 99) < 15) lmax = $urandom_range(0, thr);
        if (lmax > 65535) lmax = 65535;
        set_config(SCALE_W'(scale), LEVEL_W'(thr), LEVEL_W'(lmax));
      end
      repeat (6) begin
        r = $urandom_range(0, 99);
        if (r < 80)
          send_frame(random_data(), FRAME_PULSES, 1'b0, NO_OVER);
        else if (r < 88)
          send_frame(random_data(), $urandom_range(1, 72), 1'b0, NO_OVER);
        else if (r < 93)
          send_frame(random_data(), FRAME_PULSES, 1'b1, NO_OVER);
        else if (r < 97)
          send_frame(random_data(), FRAME_PULSES, 1'b0, 2 * $urandom_range(1, 24));
        else
          send_frame(random_data(), $urandom_range(1, 8), 1'b0, NO_OVER);
      end
      phase++;
    end
  endtask

  initial begin
    rst                     <= 1'b1;
    cfg_we                  <= 1'b0;
    cfg_index               <= REG_PULSE_SCALE;
    cfg_wdata               <= '0;
    pulse_bus.valid         <= 1'b0;
    pulse_bus.pulse_width   <= '0;
    pulse_bus.last_of_frame <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_field_checks();
    test_frame_length();
    test_config_extremes();
    test_random_frames();

    wait_idle();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && pending_frames.size() == 0)
      $display("** rf_switch_pulse_frame_decoder: PASSED **");
    else
      $display("** rf_switch_pulse_frame_decoder: FAILED **");
    $finish;
  end

  // Receiver side: random stalls with occasional always-ready stretches.
  initial begin : drive_frame_ready
    int hold;
    int r;
    hold = 0;
    frame_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          frame_bus.ready <= 1'b1;
          hold = (r < 5) ? $urandom_range(30, 150) : $urandom_range(0, 4);
        end else begin
          frame_bus.ready <= 1'b0;
          hold = (r < 95) ? $urandom_range(0, 3) : $urandom_range(4, 40);
        end
      end
    end
  end

  task automatic note_mismatch(input string what, input frame_t want, input frame_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t %s: want valid=%0b addr=%05h unit=%0d all=%0b on=%0b pkt=%0d",
               $realtime, what, want.frame_valid, want.address, want.unit, want.all_units,
               want.switch_on, want.packet_number);
      $display("%0t %s:  got valid=%0b addr=%05h unit=%0d all=%0b on=%0b pkt=%0d",
               $realtime, what, got.frame_valid, got.address, got.unit, got.all_units,
               got.switch_on, got.packet_number);
    end
  endtask

  always @(posedge clk) begin : check_frames
    frame_t got;
    frame_t want;
    if (!rst && frame_bus.valid === 1'b1 && frame_bus.ready === 1'b1) begin
      got = '{frame_bus.frame_valid, frame_bus.address, frame_bus.unit,
              frame_bus.all_units, frame_bus.switch_on, frame_bus.packet_number};
      if (pending_frames.size() == 0) begin
        note_mismatch("unexpected frame item", '0, got);
      end else begin
        want = pending_frames.pop_front();
        if (got !== want) note_mismatch("frame item mismatch", want, got);
      end
    end
  end

  // Stop a hung run: count cycles in which neither channel moves an item.
  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if ((pulse_bus.valid === 1'b1 && pulse_bus.ready === 1'b1)
        || (frame_bus.valid === 1'b1 && frame_bus.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("** rf_switch_pulse_frame_decoder: FAILED **");
        $finish;
      end
    end
  end

endmodule
